[rtl/s2dec_pkg.sv]
// Shared types, constants and functions for the signed integer to decimal ASCII unit.
// No dependencies.
package s2dec_pkg;

	localparam int ValueWidth    = 32;
	localparam int NumDigits     = 10;
	localparam int BcdWidth      = 4 * NumDigits;
	localparam int NumStages     = 4;
	localparam int StepsPerStage = ValueWidth / NumStages;
	localparam int IdxWidth      = 4;
	localparam int CharWidth     = 6;

	localparam logic [CharWidth-1:0] AsciiZero  = 6'd48;
	localparam logic [CharWidth-1:0] AsciiMinus = 6'd45;

	// one value on its way through the shift-and-add-3 conversion
	typedef struct packed {
		logic                  neg;
		logic [BcdWidth-1:0]   bcd;
		logic [ValueWidth-1:0] bin;
	} work_t;

	// one shift-and-correct iteration
	function automatic work_t dabble_step(input work_t w);
		work_t r;
		logic [BcdWidth-1:0] adj;
		adj = w.bcd;
		for (int d = 0; d < NumDigits; d++) begin
			if (adj[d*4 +: 4] >= 4'd5) begin
				adj[d*4 +: 4] = adj[d*4 +: 4] + 4'd3;
			end
		end
		r.neg = w.neg;
		{r.bcd, r.bin} = {adj[BcdWidth-2:0], w.bin, 1'b0};
		return r;
	endfunction

	function automatic work_t dabble_run(input work_t w);
		work_t r;
		r = w;
		for (int s = 0; s < StepsPerStage; s++) begin
			r = dabble_step(r);
		end
		return r;
	endfunction

	function automatic logic bcd_ok(input logic [BcdWidth-1:0] b);
		logic ok;
		ok = 1'b1;
		for (int d = 0; d < NumDigits; d++) begin
			if (b[d*4 +: 4] > 4'd9) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

[rtl/s2dec_bcd_pipe.sv]
// Binary to BCD conversion pipeline, StepsPerStage iterations per register stage.
// Depends on s2dec_pkg.
module s2dec_bcd_pipe
	import s2dec_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  work_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output work_t out_data
);

	logic [NumStages-1:0] vld_s;
	work_t                dat_s [NumStages];
	logic [NumStages-1:0] src_vld;
	work_t                src_dat [NumStages];
	logic [NumStages:0]   rdy;

	assign rdy[NumStages] = out_ready;

	for (genvar k = 0; k < NumStages; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign src_vld[k] = in_valid;
			assign src_dat[k] = in_data;
		end else begin : g_next
			assign src_vld[k] = vld_s[k-1];
			assign src_dat[k] = dat_s[k-1];
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= src_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_vld[k]) begin
				dat_s[k] <= dabble_run(src_dat[k]);
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[NumStages-1];
	assign out_data  = dat_s[NumStages-1];

	// every binary bit has been shifted into the BCD field
	a_bin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.bin == '0)
		else $error("binary bits left after last stage");

	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bcd_ok(out_data.bcd))
		else $error("BCD digit above nine");

endmodule

[rtl/s2dec_emitter.sv]
// Character serializer: turns one BCD word into a run of ASCII beats.
// Depends on s2dec_pkg.
module s2dec_emitter
	import s2dec_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  work_t                in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CharWidth-1:0] character,
	output logic                 last
);

	logic                 valid_q;
	logic                 last_q;
	logic [CharWidth-1:0] char_q;
	logic [BcdWidth-1:0]  bcd_q;
	logic [IdxWidth-1:0]  idx_q;

	logic                load;
	logic                adv;
	logic [IdxWidth-1:0] lead;
	logic [3:0]          lead_dig;
	logic [3:0]          cur_dig;

	function automatic logic [3:0] digit_at(input logic [BcdWidth-1:0] b,
		input logic [IdxWidth-1:0] idx);
		logic [3:0] r;
		r = 4'd0;
		for (int d = 0; d < NumDigits; d++) begin
			if (idx == IdxWidth'(d)) begin
				r = b[d*4 +: 4];
			end
		end
		return r;
	endfunction

	// highest nonzero digit; zero keeps a single digit
	always_comb begin
		lead = '0;
		for (int d = 0; d < NumDigits; d++) begin
			if (in_data.bcd[d*4 +: 4] != 4'd0) begin
				lead = IdxWidth'(d);
			end
		end
	end

	assign lead_dig = digit_at(in_data.bcd, lead);
	assign cur_dig  = digit_at(bcd_q, idx_q);

	assign in_ready = !valid_q || (!out_stall && last_q);
	assign load     = in_ready && in_valid;
	assign adv      = valid_q && !out_stall && !last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			last_q  <= !in_data.neg && (lead == '0);
		end else if (adv) begin
			last_q <= (idx_q == '0);
		end else if (valid_q && !out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= in_data.bcd;
			if (in_data.neg) begin
				char_q <= AsciiMinus;
				idx_q  <= lead;
			end else begin
				char_q <= AsciiZero + {2'b00, lead_dig};
				idx_q  <= lead - 1'b1;
			end
		end else if (adv) begin
			char_q <= AsciiZero + {2'b00, cur_dig};
			idx_q  <= idx_q - 1'b1;
		end
	end

	assign out_valid = valid_q;
	assign character = char_q;
	assign last      = last_q;

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !last_q |=> valid_q)
		else $error("run ended without last beat");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && char_q == AsciiMinus |-> !last_q)
		else $error("minus sign flagged last");

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> char_q == AsciiMinus || (char_q >= AsciiZero && char_q <= 6'd57))
		else $error("illegal character");

endmodule

[rtl/signed_int_to_decimal_ascii_unit.sv]
// Top level: signed 32-bit integer to decimal ASCII character stream.
// Depends on s2dec_pkg, s2dec_bcd_pipe, s2dec_emitter.
//
//  Channel | Signals                      | Direction | Beat
//  --------+------------------------------+-----------+-------------------------------
//  input   | in_valid, in_stall, value    | in        | one signed 32-bit value
//  output  | out_valid, out_stall,        | out       | one ASCII character, last
//          | character, last              |           | flags the end of the value
//
// Path: stage 1 forms sign and magnitude, four stages run eight shift-and-add-3
// iterations each, then the serializer loads its first character. The serializer
// emits one character per cycle while out_stall is low, so a value occupies the
// output for 1 to 11 character beats (minus sign plus digit count); that
// serializer sets the sustained rate, and the pipeline fills behind it.
// Reset clears only valid bits and serializer control; data registers are not reset.
// A stalled output holds the current character; stall backs up stage by stage,
// so only full stages hold and bubbles are squeezed out.
module signed_int_to_decimal_ascii_unit
	import s2dec_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [ValueWidth-1:0] value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [CharWidth-1:0]   character,
	output logic                   last
);

	logic  vld_s1;
	work_t dat_s1;
	logic  rdy_s1;

	logic  pipe_in_ready;
	logic  pipe_out_valid;
	work_t pipe_out_data;
	logic  emit_ready;

	logic [ValueWidth-1:0] raw;
	logic [ValueWidth-1:0] mag;

	// magnitude in unsigned arithmetic, so the most negative value maps to 2^31
	assign raw = value;
	assign mag = raw[ValueWidth-1] ? (~raw + 1'b1) : raw;

	assign rdy_s1   = !vld_s1 || pipe_in_ready;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			dat_s1.neg <= raw[ValueWidth-1];
			dat_s1.bcd <= '0;
			dat_s1.bin <= mag;
		end
	end

	s2dec_bcd_pipe u_bcd_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (pipe_in_ready),
		.in_data   (dat_s1),
		.out_valid (pipe_out_valid),
		.out_ready (emit_ready),
		.out_data  (pipe_out_data)
	);

	s2dec_emitter u_emitter (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pipe_out_valid),
		.in_ready  (emit_ready),
		.in_data   (pipe_out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

endmodule

[sim/tb_signed_int_to_decimal_ascii_unit.sv]
// Testbench for signed_int_to_decimal_ascii_unit: random and corner integers in, checks each
// ASCII character beat and its last flag against a built-in decimal renderer.
// Depends on s2dec_pkg and the unit RTL.
module tb_signed_int_to_decimal_ascii_unit;
	import s2dec_pkg::*;

	localparam int HalfPeriod   = 6;
	localparam int ResetCycles  = 6;
	localparam int RandomValues = 100;
	localparam int IdlePercent  = 11;
	localparam int ReportLimit  = 10;
	localparam int HoldAfter    = 200;     // characters seen before the long output hold
	localparam int HoldCycles   = 300;
	localparam int DrainCycles  = 20;      // pipeline depth plus a full 11-character run
	localparam int CycleLimit   = 200000;

	// one expected output beat
	typedef struct packed {
		logic [CharWidth-1:0] code;
		logic                 fin;
	} char_beat_t;

	// Renders every accepted value as its decimal text and holds the characters
	// still owed by the unit, oldest first.
	class decimal_text_board;
		char_beat_t owed_chars[$];
		int         errors = 0;

		function void note_value(logic signed [ValueWidth-1:0] v);
			logic [ValueWidth-1:0] raw;
			logic [ValueWidth-1:0] mag;
			logic [3:0]            digs[NumDigits];
			int                    n;
			raw = v;
			// two's complement negate in 32-bit unsigned: the most negative value
			// maps onto its own bit pattern, 2147483648
			mag = raw[ValueWidth-1] ? ValueWidth'(0 - raw) : raw;
			n = 0;
			do begin
				digs[n] = 4'(mag % 10);
				mag = mag / 10;
				n++;
			end while (mag != 0);
			if (raw[ValueWidth-1])
				owed_chars.push_back('{code: AsciiMinus, fin: 1'b0});
			for (int k = n - 1; k >= 0; k--)
				owed_chars.push_back('{code: AsciiZero + CharWidth'(digs[k]), fin: (k == 0)});
		endfunction

		function void check_char(logic [CharWidth-1:0] code, logic fin);
			char_beat_t want;
			if (owed_chars.size() == 0) begin
				errors++;
				if (errors <= ReportLimit)
					$display("unexpected character beat: code %0d last %0b", code, fin);
				return;
			end
			want = owed_chars.pop_front();
			if (want.code !== code || want.fin !== fin) begin
				errors++;
				if (errors <= ReportLimit)
					$display("character mismatch: expected code %0d last %0b, got code %0d last %0b",
						want.code, want.fin, code, fin);
			end
		endfunction

		function int owed();
			return owed_chars.size();
		endfunction
	endclass

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	logic signed [ValueWidth-1:0] value     = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [CharWidth-1:0]         character;
	logic                         last;

	decimal_text_board board = new();
	bit  calm       = 1'b0;   // no idling on either side while set
	int  chars_seen = 0;
	int  cycles     = 0;

	signed_int_to_decimal_ascii_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	always begin
		clk = 1'b1;
		#HalfPeriod;
		clk = 1'b0;
		#HalfPeriod;
	end

	// Hard stop: the slowest legal run is well under a tenth of this.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one value; returns at the edge where the beat is taken. in_valid stays
	// high afterwards so the next call can stream back to back.
	task automatic send_value(input logic signed [ValueWidth-1:0] v);
		while (!calm && $urandom_range(99) < IdlePercent) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
		board.note_value(v);
	endtask

	// Random value shaped to hit every digit count and the decade borders,
	// with plenty of raw 32-bit patterns so every input bit toggles.
	function automatic logic signed [ValueWidth-1:0] pick_value();
		int                    kind;
		int                    ndig;
		logic [ValueWidth-1:0] mag;
		logic [ValueWidth-1:0] p10;
		logic                  neg;
		kind = $urandom_range(9);
		neg  = $urandom_range(1);
		if (kind <= 3)
			return $urandom;
		if (kind == 9) begin
			case ($urandom_range(4))
				0: return 0;
				1: return 32'sh7FFFFFFF;
				2: return 32'sh80000000;
				3: return 1;
				default: return -1;
			endcase
		end
		ndig = $urandom_range(NumDigits, 1);
		p10  = 1;
		for (int i = 1; i < ndig; i++)
			p10 = p10 * 10;
		if (kind <= 6) begin
			// any magnitude with exactly ndig digits
			if (ndig == NumDigits)
				mag = $urandom_range(32'h7FFFFFFF, p10);
			else
				mag = $urandom_range(p10 * 10 - 1, (ndig == 1) ? 0 : p10);
		end else begin
			// the power of ten itself or one either side of it
			mag = p10 + $urandom_range(2) - 1;
		end
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	// Output side: checks each taken beat, then picks the stall for the next edge.
	// Once enough text has come out it holds off for a long stretch so the
	// pipeline fills and pushes back on the input.
	initial begin
		int  hold_left;
		bit  held;
		hold_left = 0;
		held      = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				board.check_char(character, last);
				chars_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!held && chars_seen >= HoldAfter) begin
				held      = 1'b1;
				hold_left = HoldCycles - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IdlePercent);
			end
		end
	end

	// Corner values: zero, single digits, decade borders, both extremes, the
	// most negative value and alternating bit patterns.
	logic signed [ValueWidth-1:0] corner_values[] = '{
		0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
		32'sh7FFFFFFF, 32'sh80000000, -32'sh7FFFFFFF,
		1000000000, -1000000000, 999999999, 123456789, -123456789,
		32'sh55555555, 32'shAAAAAAAA
	};

	initial begin
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (corner_values[i])
			send_value(corner_values[i]);

		for (int i = 0; i < RandomValues; i++) begin
			// a stretch in the middle runs with no idling on either side
			calm = (i >= 50 && i < 90);
			send_value(pick_value());
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (board.owed() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (board.errors == 0 && board.owed() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
